### design/sau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sau_pkg
// Shared types and constants for the sort-and-unique block.
// ----------------------------------------------------------------------------
`default_nettype none

package sau_pkg;

   // number of cells in the sorting row
   localparam int MAX_LEN = 64;
   // value and tolerance widths
   localparam int VAL_W   = 32;
   localparam int TOL_W   = 31;
   // fill count must also hold MAX_LEN itself
   localparam int CNT_W   = $clog2(MAX_LEN + 1);

   typedef logic signed [VAL_W-1:0] val_type;
   typedef logic [CNT_W-1:0]        cnt_type;
   typedef logic [TOL_W-1:0]        tol_type;

   // control sent to every cell of the row
   typedef struct packed {
      logic insert;  // place the broadcast value in sorted position
      logic shift;   // move every value one cell toward the head
   } ctl_type;

endpackage

`default_nettype wire

### design/sau_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sau_cell
// One cell of the insertion-sort row: holds one value, takes its left neighbor's
// or the new value on insertion, its right neighbor's value on shift-out.
// ----------------------------------------------------------------------------
`default_nettype none

module sau_cell (
   input  wire                    clock,
   input  wire sau_pkg::ctl_type  ctl,
   input  wire sau_pkg::val_type  new_value,
   input  wire                    occupied,
   input  wire                    left_occupied,
   input  wire                    left_greater,
   input  wire sau_pkg::val_type  left_value,
   input  wire sau_pkg::val_type  right_value,
   output logic                   greater,
   output sau_pkg::val_type       value
);
   import sau_pkg::*;

   val_type value_ff;
   val_type value_in;

   // held value lies above the incoming one
   assign greater = occupied && (value_ff > new_value);
   assign value   = value_ff;

   // next value of this cell
   always_comb begin
      value_in = value_ff;
      if (ctl.shift) begin
         value_in = right_value;
      end else if (ctl.insert) begin
         if (greater || (!occupied && left_occupied)) begin
            value_in = left_greater ? left_value : new_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

`default_nettype wire

### design/sau_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sau_chain
// Row of sorting cells, ascending from the head; occupancy follows the count.
// ----------------------------------------------------------------------------
`default_nettype none

module sau_chain (
   input  wire                    clock,
   input  wire sau_pkg::ctl_type  ctl,
   input  wire sau_pkg::val_type  new_value,
   input  wire sau_pkg::cnt_type  count,
   output sau_pkg::val_type       head_value
);
   import sau_pkg::*;

   val_type           cell_value [MAX_LEN];
   logic [MAX_LEN-1:0] cell_greater;
   logic [MAX_LEN-1:0] cell_occupied;

   // cell i holds a value while i is below the fill count
   always_comb begin
      for (int i = 0; i < MAX_LEN; i++) begin
         cell_occupied[i] = (CNT_W'(i) < count);
      end
   end

   for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
      logic    left_occ;
      logic    left_gt;
      val_type left_val;
      val_type right_val;

      // head cell sees an occupied, never-greater left boundary
      if (i == 0) begin : g_head
         assign left_occ = 1'b1;
         assign left_gt  = 1'b0;
         assign left_val = new_value;
      end else begin : g_body
         assign left_occ = cell_occupied[i-1];
         assign left_gt  = cell_greater[i-1];
         assign left_val = cell_value[i-1];
      end

      // tail cell keeps its own value on shift
      if (i == MAX_LEN - 1) begin : g_tail
         assign right_val = cell_value[i];
      end else begin : g_mid
         assign right_val = cell_value[i+1];
      end

      sau_cell u_cell (
         .clock         (clock),
         .ctl           (ctl),
         .new_value     (new_value),
         .occupied      (cell_occupied[i]),
         .left_occupied (left_occ),
         .left_greater  (left_gt),
         .left_value    (left_val),
         .right_value   (right_val),
         .greater       (cell_greater[i]),
         .value         (cell_value[i])
      );
   end

   assign head_value = cell_value[0];

endmodule

`default_nettype wire

### design/sort_and_unique_values.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sort_and_unique_values
// Sorts one series of signed Q16.16 values and emits the unique ones.
// ----------------------------------------------------------------------------
// Usage:
//  - input: a transaction is taken on a clock edge with start high and busy
//    low; req_value is one series element, req_last_in ends the series.
//  - while filling, one element is taken every cycle: each is inserted into
//    a row of 64 cells in sorted position in the cycle it arrives.
//  - elements beyond 64 are dropped and every result of that series carries
//    rsp_overflow; a dropped element marked last still ends the series.
//  - after the last element, busy stays high until the row has drained and
//    the last result is out; the row shifts out one value per cycle at the head.
//  - results appear on rsp_* for one cycle each, marked by rsp_valid: each
//    kept value once the next one is kept, the last with rsp_last_out in the
//    same cycle that busy falls. The receiver cannot stall the block.
//  - a value is dropped when it lies less than the tolerance above the last
//    value kept. csr_write_en loads the tolerance; write it only when idle.
//  - reset empties the row, clears the overflow flag and sets tolerance 1.
// ----------------------------------------------------------------------------
`default_nettype none

module sort_and_unique_values (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   output logic                   busy,
   input  wire sau_pkg::val_type  req_value,
   input  wire                    req_last_in,
   input  wire                    csr_write_en,
   input  wire sau_pkg::tol_type  csr_write_data,
   output logic                   rsp_valid,
   output sau_pkg::val_type       rsp_sorted_value,
   output logic                   rsp_last_out,
   output logic                   rsp_overflow
);
   import sau_pkg::*;

   typedef enum logic {
      ST_FILL,
      ST_DRAIN
   } state_type;

   state_type state_ff;
   cnt_type   count_ff;
   logic      overflow_ff;
   tol_type   tol_ff;
   val_type   pend_ff;
   logic      have_ff;
   logic      rsp_valid_ff;
   val_type   rsp_value_ff;
   logic      rsp_last_ff;
   logic      rsp_overflow_ff;

   ctl_type            ctl;
   val_type            head_value;
   logic               accept;
   logic               full;
   logic signed [VAL_W:0] diff;
   logic               keep;

   assign accept = start && (state_ff == ST_FILL);
   assign full   = (count_ff == CNT_W'(MAX_LEN));

   // row control
   always_comb begin
      ctl.insert = accept && !full;
      ctl.shift  = (state_ff == ST_DRAIN) && (count_ff != '0);
   end

   sau_chain u_chain (
      .clock      (clock),
      .ctl        (ctl),
      .new_value  (req_value),
      .count      (count_ff),
      .head_value (head_value)
   );

   // keep the head if it is the first value or far enough above the last kept
   assign diff = {head_value[VAL_W-1], head_value} - {pend_ff[VAL_W-1], pend_ff};
   assign keep = !have_ff || (diff >= $signed({2'b00, tol_ff}));

   // tolerance register
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_W'(1);
      end else if (csr_write_en) begin
         tol_ff <= csr_write_data;
      end
   end

   // fill and drain sequencing with registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_FILL: begin
               if (accept) begin
                  if (full) begin
                     overflow_ff <= 1'b1;
                  end else begin
                     count_ff <= count_ff + CNT_W'(1);
                  end
                  if (req_last_in) begin
                     state_ff <= ST_DRAIN;
                  end
               end
            end
            ST_DRAIN: begin
               if (count_ff != '0) begin
                  count_ff <= count_ff - CNT_W'(1);
                  if (keep) begin
                     // a newer kept value releases the pending one
                     if (have_ff) begin
                        rsp_valid_ff    <= 1'b1;
                        rsp_value_ff    <= pend_ff;
                        rsp_last_ff     <= 1'b0;
                        rsp_overflow_ff <= overflow_ff;
                     end
                     pend_ff <= head_value;
                     have_ff <= 1'b1;
                  end
               end else begin
                  // row empty: pending value is the final result
                  rsp_valid_ff    <= have_ff;
                  rsp_value_ff    <= pend_ff;
                  rsp_last_ff     <= 1'b1;
                  rsp_overflow_ff <= overflow_ff;
                  have_ff         <= 1'b0;
                  overflow_ff     <= 1'b0;
                  state_ff        <= ST_FILL;
               end
            end
            default: begin
               state_ff <= ST_FILL;
            end
         endcase
      end
   end

   assign busy             = (state_ff == ST_DRAIN);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_last_out     = rsp_last_ff;
   assign rsp_overflow     = rsp_overflow_ff;

endmodule

`default_nettype wire
